@@ sv/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on aclk, off while aresetn is low
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("port check failed");

// next-cycle implication, sampled on aclk, off while aresetn is low
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("port check failed");

`endif

@@ sv/bra_pkg.sv @@
// types and constants of the bitmap run allocator
package bra_pkg;

    // field widths
    localparam int FUNC_W     = 2;
    localparam int INDEX_W    = 21;
    localparam int COUNT_W    = 13;
    localparam int BASE_W     = 20;
    localparam int LEN_W      = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;

    // register reset values
    localparam logic [BASE_W-1:0] BASE_RESET = '0;
    localparam logic [LEN_W-1:0]  LEN_RESET  = 10'd512;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_BYTES = 1'b1;

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TEST  = 2'd0,
        FUNC_SET   = 2'd1,
        FUNC_SCAN  = 2'd2,
        FUNC_CLEAR = 2'd3
    } func_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_ACCESS,
        S_MODIFY,
        S_SCAN,
        S_MARK,
        S_WIPE,
        S_DONE
    } state_t;

    // result of walking one byte of the map
    typedef struct packed {
        logic               hit;
        logic [2:0]         hit_pos;
        logic [COUNT_W-1:0] run_next;
    } scan_res_t;

endpackage

@@ sv/bitmap_run_allocator.sv @@
// bitmap run allocator: test, set, first-fit scan and clear over a byte memory
// steps: test and set pass access, modify, done (no modify when out of map); clear
// wipes each byte; scan reads the effective length, marks a hit; one byte read a cycle
// throughput: one item at a time, the next taken as soon as the result is registered
// reset: synchronous, active low; a clearing pass over every byte follows,
// with the input held off (configuration writes still taken)
module bitmap_run_allocator #(
    parameter int MAP_BYTES = 512
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_wr_en,
    input  logic [bra_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bra_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [bra_pkg::FUNC_W-1:0]     s_func,
    input  logic [bra_pkg::INDEX_W-1:0]    s_bit_index,
    input  logic                           s_set_value,
    input  logic [bra_pkg::COUNT_W-1:0]    s_run_length,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_bit_value,
    output logic                           m_found,
    output logic [bra_pkg::INDEX_W-1:0]    m_run_start,
    output logic                           m_status
);

    localparam int AW  = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int BW  = $clog2(MAP_BYTES + 1);
    localparam int UAW = AW + 3;
    localparam int UCW = BW + 3;
    localparam logic [AW-1:0] LAST_BYTE = AW'(MAP_BYTES - 1);
    localparam logic [BW-1:0] MAP_BYTES_B = BW'(MAP_BYTES);

    // byte memory holding the map
    logic [7:0]    mem [MAP_BYTES];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata_reg;

    // registers
    bra_pkg::state_t                state_reg, state_next;
    logic [bra_pkg::BASE_W-1:0]     base_reg;
    logic [bra_pkg::LEN_W-1:0]      len_reg;
    bra_pkg::func_t                 func_reg, func_next;
    logic [bra_pkg::INDEX_W-1:0]    idx_reg, idx_next;
    logic                           val_reg, val_next;
    logic [bra_pkg::COUNT_W-1:0]    cnt_reg, cnt_next;
    logic [bra_pkg::COUNT_W-1:0]    run_reg, run_next;
    logic [AW-1:0]                  clr_addr_reg, clr_addr_next;
    logic [BW-1:0]                  scan_addr_reg, scan_addr_next;
    logic [AW-1:0]                  eval_addr_reg, eval_addr_next;
    logic                           pend_reg, pend_next;
    logic [UAW-1:0]                 start_reg, start_next;
    logic [UAW-1:0]                 end_reg, end_next;
    logic [BW-1:0]                  mk_addr_reg, mk_addr_next;
    logic [AW-1:0]                  mk_wr_addr_reg, mk_wr_addr_next;
    logic                           res_bit_reg, res_bit_next;
    logic                           res_found_reg, res_found_next;
    logic [bra_pkg::INDEX_W-1:0]    res_start_reg, res_start_next;
    logic                           res_status_reg, res_status_next;
    logic                           m_valid_reg, m_valid_next;
    logic                           m_bit_reg, m_bit_next;
    logic                           m_found_reg, m_found_next;
    logic [bra_pkg::INDEX_W-1:0]    m_start_reg, m_start_next;
    logic                           m_status_reg, m_status_next;

    // derived conditions
    logic                           s_xfer;
    logic                           out_free;
    logic [BW-1:0]                  eff_bytes;
    logic [UCW-1:0]                 units;
    logic                           idx_below;
    logic [bra_pkg::INDEX_W-1:0]    idx_diff;
    logic                           idx_oob;
    logic [UAW-1:0]                 acc_unit;
    logic                           scan_issue;
    logic                           scan_hit;
    logic [UAW-1:0]                 hit_end;
    logic [UAW-1:0]                 hit_start;
    logic [AW-1:0]                  end_byte;
    logic [AW-1:0]                  start_byte;
    logic                           mk_issue;
    logic [2:0]                     mk_lo;
    logic [2:0]                     mk_hi;
    logic [7:0]                     mk_mask;
    bra_pkg::scan_res_t             sres;

    // memory port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    // byte walker
    bra_run_scan u_scan (
        .byte_data (mem_rdata_reg),
        .run_in    (run_reg),
        .count     (cnt_reg),
        .res       (sres)
    );

    // handshakes
    assign s_ready  = (state_reg == bra_pkg::S_IDLE);
    assign s_xfer   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // map size clipped to the memory
    assign eff_bytes = (32'(len_reg) >= 32'(MAP_BYTES)) ? MAP_BYTES_B : BW'(len_reg);
    assign units     = {eff_bytes, 3'b000};

    // index range check for test and set
    assign idx_below = idx_reg < {1'b0, base_reg};
    assign idx_diff  = idx_reg - {1'b0, base_reg};
    assign idx_oob   = idx_below || (32'(idx_diff) >= 32'(units));
    assign acc_unit  = idx_diff[UAW-1:0];

    // scan bookkeeping
    assign scan_issue = scan_addr_reg < eff_bytes;
    assign scan_hit   = pend_reg && sres.hit;
    assign hit_end    = {eval_addr_reg, sres.hit_pos};
    assign hit_start  = UAW'(32'(hit_end) + 32'd1 - 32'(cnt_reg));

    // marking bookkeeping
    assign end_byte   = end_reg[UAW-1:3];
    assign start_byte = start_reg[UAW-1:3];
    assign mk_issue   = 32'(mk_addr_reg) <= 32'(end_byte);
    assign mk_lo      = (mk_wr_addr_reg == start_byte) ? start_reg[2:0] : 3'd0;
    assign mk_hi      = (mk_wr_addr_reg == end_byte) ? end_reg[2:0] : 3'd7;

    // units of the run that fall in the byte being written back
    always_comb begin
        for (int j = 0; j < 8; j++) begin
            mk_mask[j] = (3'(j) >= mk_lo) && (3'(j) <= mk_hi);
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bra_pkg::S_INIT: begin
                if (clr_addr_reg == LAST_BYTE) begin
                    state_next = bra_pkg::S_IDLE;
                end
            end
            bra_pkg::S_IDLE: begin
                if (s_xfer) begin
                    state_next = bra_pkg::S_ACCESS;
                end
            end
            bra_pkg::S_ACCESS: begin
                case (func_reg)
                    bra_pkg::FUNC_TEST, bra_pkg::FUNC_SET: begin
                        state_next = idx_oob ? bra_pkg::S_DONE : bra_pkg::S_MODIFY;
                    end
                    bra_pkg::FUNC_SCAN: begin
                        state_next = (cnt_reg == '0) ? bra_pkg::S_DONE : bra_pkg::S_SCAN;
                    end
                    default: begin
                        state_next = bra_pkg::S_WIPE;
                    end
                endcase
            end
            bra_pkg::S_MODIFY: begin
                state_next = bra_pkg::S_DONE;
            end
            bra_pkg::S_SCAN: begin
                if (scan_hit) begin
                    state_next = bra_pkg::S_MARK;
                end else if (!pend_reg && !scan_issue) begin
                    state_next = bra_pkg::S_DONE;
                end
            end
            bra_pkg::S_MARK: begin
                if (!pend_reg && !mk_issue) begin
                    state_next = bra_pkg::S_DONE;
                end
            end
            bra_pkg::S_WIPE: begin
                if (clr_addr_reg == LAST_BYTE) begin
                    state_next = bra_pkg::S_DONE;
                end
            end
            bra_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = bra_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bra_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb begin
        mem_we          = 1'b0;
        mem_waddr       = mk_wr_addr_reg;
        mem_wdata       = mem_rdata_reg;
        mem_re          = 1'b0;
        mem_raddr       = acc_unit[UAW-1:3];
        func_next       = func_reg;
        idx_next        = idx_reg;
        val_next        = val_reg;
        cnt_next        = cnt_reg;
        run_next        = run_reg;
        clr_addr_next   = clr_addr_reg;
        scan_addr_next  = scan_addr_reg;
        eval_addr_next  = eval_addr_reg;
        pend_next       = pend_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        mk_addr_next    = mk_addr_reg;
        mk_wr_addr_next = mk_wr_addr_reg;
        res_bit_next    = res_bit_reg;
        res_found_next  = res_found_reg;
        res_start_next  = res_start_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_bit_next      = m_bit_reg;
        m_found_next    = m_found_reg;
        m_start_next    = m_start_reg;
        m_status_next   = m_status_reg;

        case (state_reg)
            // clearing sweeps, one byte a cycle
            bra_pkg::S_INIT, bra_pkg::S_WIPE: begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + AW'(1);
            end
            // capture the transfer
            bra_pkg::S_IDLE: begin
                if (s_xfer) begin
                    func_next       = bra_pkg::func_t'(s_func);
                    idx_next        = s_bit_index;
                    val_next        = s_set_value;
                    cnt_next        = s_run_length;
                    res_bit_next    = 1'b0;
                    res_found_next  = 1'b0;
                    res_start_next  = '0;
                    res_status_next = 1'b0;
                end
            end
            // range checks, first read
            bra_pkg::S_ACCESS: begin
                case (func_reg)
                    bra_pkg::FUNC_TEST, bra_pkg::FUNC_SET: begin
                        if (idx_oob) begin
                            res_status_next = 1'b1;
                        end else begin
                            mem_re = 1'b1;
                        end
                    end
                    bra_pkg::FUNC_SCAN: begin
                        if (cnt_reg == '0) begin
                            res_status_next = 1'b1;
                        end
                        run_next       = '0;
                        scan_addr_next = '0;
                        pend_next      = 1'b0;
                    end
                    default: begin
                        clr_addr_next = '0;
                    end
                endcase
            end
            // test reads the bit, set writes the byte back
            bra_pkg::S_MODIFY: begin
                if (func_reg == bra_pkg::FUNC_TEST) begin
                    res_bit_next = mem_rdata_reg[acc_unit[2:0]];
                end else begin
                    mem_we                    = 1'b1;
                    mem_waddr                 = acc_unit[UAW-1:3];
                    mem_wdata                 = mem_rdata_reg;
                    mem_wdata[acc_unit[2:0]]  = val_reg;
                end
            end
            // streamed byte reads, each byte judged the cycle after its read
            bra_pkg::S_SCAN: begin
                if (scan_hit) begin
                    pend_next      = 1'b0;
                    start_next     = hit_start;
                    end_next       = hit_end;
                    mk_addr_next   = BW'(hit_start[UAW-1:3]);
                    res_found_next = 1'b1;
                    res_start_next = bra_pkg::INDEX_W'(32'(hit_start) + 32'(base_reg));
                end else begin
                    if (pend_reg) begin
                        run_next = sres.run_next;
                    end
                    if (scan_issue) begin
                        mem_re         = 1'b1;
                        mem_raddr      = scan_addr_reg[AW-1:0];
                        eval_addr_next = scan_addr_reg[AW-1:0];
                        scan_addr_next = scan_addr_reg + BW'(1);
                        pend_next      = 1'b1;
                    end else begin
                        pend_next = 1'b0;
                    end
                end
            end
            // mark the run: read ahead, write back the byte read last cycle
            bra_pkg::S_MARK: begin
                if (pend_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = mk_wr_addr_reg;
                    mem_wdata = mem_rdata_reg | mk_mask;
                end
                if (mk_issue) begin
                    mem_re          = 1'b1;
                    mem_raddr       = mk_addr_reg[AW-1:0];
                    mk_wr_addr_next = mk_addr_reg[AW-1:0];
                    mk_addr_next    = mk_addr_reg + BW'(1);
                    pend_next       = 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
            end
            // hand the result to the output register
            bra_pkg::S_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_bit_next    = res_bit_reg;
                    m_found_next  = res_found_reg;
                    m_start_next  = res_start_reg;
                    m_status_next = res_status_reg;
                end
            end
            default: begin
                pend_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= bra_pkg::S_INIT;
            clr_addr_reg <= '0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            pend_reg     <= pend_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= bra_pkg::BASE_RESET;
            len_reg  <= bra_pkg::LEN_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bra_pkg::REG_BASE_OFFSET: begin
                    base_reg <= cfg_wdata[bra_pkg::BASE_W-1:0];
                end
                bra_pkg::REG_LENGTH_BYTES: begin
                    len_reg <= cfg_wdata[bra_pkg::LEN_W-1:0];
                end
                default: begin
                    base_reg <= base_reg;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        func_reg       <= func_next;
        idx_reg        <= idx_next;
        val_reg        <= val_next;
        cnt_reg        <= cnt_next;
        run_reg        <= run_next;
        scan_addr_reg  <= scan_addr_next;
        eval_addr_reg  <= eval_addr_next;
        start_reg      <= start_next;
        end_reg        <= end_next;
        mk_addr_reg    <= mk_addr_next;
        mk_wr_addr_reg <= mk_wr_addr_next;
        res_bit_reg    <= res_bit_next;
        res_found_reg  <= res_found_next;
        res_start_reg  <= res_start_next;
        res_status_reg <= res_status_next;
        m_bit_reg      <= m_bit_next;
        m_found_reg    <= m_found_next;
        m_start_reg    <= m_start_next;
        m_status_reg   <= m_status_next;
    end

    // result channel
    assign m_valid     = m_valid_reg;
    assign m_bit_value = m_bit_reg;
    assign m_found     = m_found_reg;
    assign m_run_start = m_start_reg;
    assign m_status    = m_status_reg;

endmodule

@@ sv/bra_run_scan.sv @@
// run counter over the eight units of one bitmap byte
module bra_run_scan (
    input  logic [7:0]                  byte_data,
    input  logic [bra_pkg::COUNT_W-1:0] run_in,
    input  logic [bra_pkg::COUNT_W-1:0] count,
    output bra_pkg::scan_res_t          res
);

    // walk the units lowest first, note the first unit that completes the run
    always_comb begin
        logic [bra_pkg::COUNT_W-1:0] run;
        logic                        hit;
        logic [2:0]                  pos;
        run = run_in;
        hit = 1'b0;
        pos = '0;
        for (int j = 0; j < 8; j++) begin
            run = byte_data[j] ? '0 : run + bra_pkg::COUNT_W'(1);
            if (!hit && run == count) begin
                hit = 1'b1;
                pos = 3'(j);
            end
        end
        res.hit      = hit;
        res.hit_pos  = pos;
        res.run_next = run;
    end

endmodule

@@ sv/bra_checker.sv @@
// port-level checks of the bitmap run allocator and their binding
`include "assert_macros.svh"

module bra_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic                        m_bit_value,
    input logic                        m_found,
    input logic [bra_pkg::INDEX_W-1:0] m_run_start,
    input logic                        m_status
);

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_run_start) && $stable(m_found) && $stable(m_status) && $stable(m_bit_value))

    // one item at a time: the input closes after each transfer
    `ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready)

    // an allocation is never an error and carries no test bit
    `ASSERT_IMPLIES(a_found_clean, m_valid && m_found, !m_status && !m_bit_value)

    // errors report nothing else
    `ASSERT_IMPLIES(a_error_clean, m_valid && m_status, !m_found && !m_bit_value)

    // no allocation, no start index
    `ASSERT_IMPLIES(a_miss_zero, m_valid && !m_found, m_run_start == '0)

endmodule

bind bitmap_run_allocator bra_checker u_bra_checker (.*);
